// ===== hdl/mmc_pkg.sv =====
// shared types, constants and helpers for the masked mean colour block
package mmc_pkg;

    // widths of the accumulators and channels
    localparam int COUNT_BITS   = 16;
    localparam int TOTAL_BITS   = 24;
    localparam int CHAN_BITS    = 8;
    localparam int NUM_CHAN     = 3;
    localparam int CHAN_IDX_BITS = $clog2(NUM_CHAN);
    localparam int STEP_BITS    = $clog2(CHAN_BITS);
    localparam int CFG_IDX_BITS = 2;

    // divider datapath holds both a total and a count shifted by a channel width
    localparam int CMP_BITS =
        ((TOTAL_BITS > COUNT_BITS + CHAN_BITS) ? TOTAL_BITS : COUNT_BITS + CHAN_BITS) + 1;

    // job queue between accumulator and divider
    localparam int QDEPTH     = 2;
    localparam int QPTR_BITS  = $clog2(QDEPTH);
    localparam int QCNT_BITS  = QPTR_BITS + 1;

    localparam logic [COUNT_BITS-1:0]    COUNT_MAX = '1;
    localparam logic [TOTAL_BITS-1:0]    TOTAL_MAX = '1;
    localparam logic [CHAN_BITS-1:0]     MEAN_MAX  = '1;
    localparam logic [CHAN_IDX_BITS-1:0] LAST_CHAN = CHAN_IDX_BITS'(NUM_CHAN - 1);
    localparam logic [STEP_BITS-1:0]     LAST_STEP = STEP_BITS'(CHAN_BITS - 1);

    // register reset values
    localparam logic [CHAN_BITS-1:0] RST_ALPHA_THRESHOLD = 8'd128;
    localparam logic [CHAN_BITS-1:0] RST_DEFAULT_RED     = 8'd29;
    localparam logic [CHAN_BITS-1:0] RST_DEFAULT_GREEN   = 8'd185;
    localparam logic [CHAN_BITS-1:0] RST_DEFAULT_BLUE    = 8'd84;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ALPHA_THRESHOLD = 2'd0,
        CFG_DEFAULT_RED     = 2'd1,
        CFG_DEFAULT_GREEN   = 2'd2,
        CFG_DEFAULT_BLUE    = 2'd3
    } t_cfg_reg;

    // divider sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LOAD,
        BK_STEP,
        BK_PUSH
    } t_back_state;

    typedef struct packed {
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
        logic [CHAN_BITS-1:0] alpha;
        logic                 last_pixel;
    } t_pixel;

    typedef struct packed {
        logic [CHAN_BITS-1:0] mean_red;
        logic [CHAN_BITS-1:0] mean_green;
        logic [CHAN_BITS-1:0] mean_blue;
        logic                 used_default;
        logic                 count_saturated;
    } t_result;

    // one finished image waiting for its division
    typedef struct packed {
        logic [TOTAL_BITS-1:0] red_total;
        logic [TOTAL_BITS-1:0] green_total;
        logic [TOTAL_BITS-1:0] blue_total;
        logic [COUNT_BITS-1:0] kept_count;
        logic                  saturated;
    } t_job;

    typedef struct packed {
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
    } t_colour;

    // queue status seen by both sides
    typedef struct packed {
        logic valid;
        logic full;
    } t_q_stat;

    typedef struct packed {
        logic [TOTAL_BITS-1:0] value;
        logic                  ovf;
    } t_sat_sum;

    // saturating add of one channel value onto a running total
    function automatic t_sat_sum sat_add(input logic [TOTAL_BITS-1:0] total,
                                         input logic [CHAN_BITS-1:0] add);
        logic [TOTAL_BITS:0] sum;
        t_sat_sum res;
        sum = {1'b0, total} + (TOTAL_BITS+1)'(add);
        res.ovf   = sum[TOTAL_BITS];
        res.value = sum[TOTAL_BITS] ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
        return res;
    endfunction

endpackage

// ===== hdl/masked_mean_color.sv =====
// masked mean colour: pixels at one per cycle while the queue is not full; each image
// result follows its last pixel: the idle state picks up the job, then per channel a load
// state and 8 restoring divider steps (only the load state when the mean clamps), 3 channels
// in turn, then the push state fills the output register once it is free; an empty image
// skips the divider. the queue holds two finished images, the one under division included;
// pixels stall only when it is full. synchronous active-low reset clears accumulators,
// queue and output valid and loads threshold 128 and default colour 29/185/84.
module masked_mean_color (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  mmc_pkg::t_pixel                  i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output mmc_pkg::t_result                 o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mmc_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [mmc_pkg::CHAN_BITS-1:0]    i_cfg_data
);

    logic [mmc_pkg::CHAN_BITS-1:0] r_alpha_threshold;
    mmc_pkg::t_colour              r_defaults;

    mmc_pkg::t_q_stat q_stat;
    mmc_pkg::t_job    push_job;
    mmc_pkg::t_job    head_job;
    logic             push;
    logic             pop;

    // configuration registers, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_threshold <= mmc_pkg::RST_ALPHA_THRESHOLD;
            r_defaults.red    <= mmc_pkg::RST_DEFAULT_RED;
            r_defaults.green  <= mmc_pkg::RST_DEFAULT_GREEN;
            r_defaults.blue   <= mmc_pkg::RST_DEFAULT_BLUE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (mmc_pkg::t_cfg_reg'(i_cfg_index))
                mmc_pkg::CFG_ALPHA_THRESHOLD: r_alpha_threshold <= i_cfg_data;
                mmc_pkg::CFG_DEFAULT_RED:     r_defaults.red    <= i_cfg_data;
                mmc_pkg::CFG_DEFAULT_GREEN:   r_defaults.green  <= i_cfg_data;
                mmc_pkg::CFG_DEFAULT_BLUE:    r_defaults.blue   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // pixel intake and accumulation
    mmc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_threshold (r_alpha_threshold),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_job       (push_job)
    );

    // finished images waiting for division
    mmc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_stat  (q_stat),
        .o_head  (head_job)
    );

    // division and result delivery
    mmc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_job       (head_job),
        .o_pop       (pop),
        .i_defaults  (r_defaults),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== hdl/mmc_front.sv =====
// pixel intake: alpha test and saturating accumulation per image
module mmc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  mmc_pkg::t_pixel               i_in_data,
    input  logic [mmc_pkg::CHAN_BITS-1:0] i_threshold,
    input  mmc_pkg::t_q_stat              i_q_stat,
    output logic                          o_push,
    output mmc_pkg::t_job                 o_job
);

    logic [mmc_pkg::TOTAL_BITS-1:0] r_red_total,   n_red_total;
    logic [mmc_pkg::TOTAL_BITS-1:0] r_green_total, n_green_total;
    logic [mmc_pkg::TOTAL_BITS-1:0] r_blue_total,  n_blue_total;
    logic [mmc_pkg::COUNT_BITS-1:0] r_kept_count,  n_kept_count;
    logic                           r_saturated,   n_saturated;

    logic             accept;
    logic             kept;
    mmc_pkg::t_sat_sum red_sum, green_sum, blue_sum;

    // a full queue holds off every pixel so a last pixel always finds room
    assign o_in_stall = i_q_stat.full;
    assign accept     = i_in_valid && !i_q_stat.full;
    assign kept       = i_in_data.alpha >= i_threshold;

    assign red_sum   = mmc_pkg::sat_add(r_red_total,   i_in_data.red);
    assign green_sum = mmc_pkg::sat_add(r_green_total, i_in_data.green);
    assign blue_sum  = mmc_pkg::sat_add(r_blue_total,  i_in_data.blue);

    // next accumulator values including the current pixel
    always_comb begin
        n_red_total   = r_red_total;
        n_green_total = r_green_total;
        n_blue_total  = r_blue_total;
        n_kept_count  = r_kept_count;
        n_saturated   = r_saturated;
        if (accept && kept) begin
            if (r_kept_count == mmc_pkg::COUNT_MAX) begin
                n_saturated = 1'b1;
            end else begin
                n_red_total   = red_sum.value;
                n_green_total = green_sum.value;
                n_blue_total  = blue_sum.value;
                n_kept_count  = r_kept_count + 1'b1;
                n_saturated   = r_saturated | red_sum.ovf | green_sum.ovf | blue_sum.ovf;
            end
        end
    end

    // hand the finished image to the queue on its last pixel
    assign o_push            = accept && i_in_data.last_pixel;
    assign o_job.red_total   = n_red_total;
    assign o_job.green_total = n_green_total;
    assign o_job.blue_total  = n_blue_total;
    assign o_job.kept_count  = n_kept_count;
    assign o_job.saturated   = n_saturated;

    // accumulators, cleared after each image
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_red_total   <= '0;
            r_green_total <= '0;
            r_blue_total  <= '0;
            r_kept_count  <= '0;
            r_saturated   <= 1'b0;
        end else begin
            r_red_total   <= n_red_total;
            r_green_total <= n_green_total;
            r_blue_total  <= n_blue_total;
            r_kept_count  <= n_kept_count;
            r_saturated   <= n_saturated;
        end
    end

endmodule

// ===== hdl/mmc_queue.sv =====
// short fifo of finished image jobs between accumulator and divider
module mmc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mmc_pkg::t_job    i_job,
    input  logic             i_pop,
    output mmc_pkg::t_q_stat o_stat,
    output mmc_pkg::t_job    o_head
);

    mmc_pkg::t_job                  r_mem [mmc_pkg::QDEPTH];
    logic [mmc_pkg::QPTR_BITS-1:0] r_wptr;
    logic [mmc_pkg::QPTR_BITS-1:0] r_rptr;
    logic [mmc_pkg::QCNT_BITS-1:0] r_count;

    assign o_stat.valid = r_count != '0;
    assign o_stat.full  = r_count == mmc_pkg::QCNT_BITS'(mmc_pkg::QDEPTH);
    assign o_head       = r_mem[r_rptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/mmc_back.sv =====
// per-image mean: shared restoring divider over three channels and output register
module mmc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mmc_pkg::t_q_stat i_q_stat,
    input  mmc_pkg::t_job    i_job,
    output logic             o_pop,
    input  mmc_pkg::t_colour i_defaults,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output mmc_pkg::t_result o_out_data
);

    mmc_pkg::t_back_state r_state, n_state;

    logic [mmc_pkg::CHAN_IDX_BITS-1:0] r_chan, n_chan;
    logic [mmc_pkg::STEP_BITS-1:0]     r_step, n_step;
    logic [mmc_pkg::CMP_BITS-1:0]      r_rem,  n_rem;
    logic [mmc_pkg::CMP_BITS-1:0]      r_dsr,  n_dsr;
    logic [mmc_pkg::CHAN_BITS-1:0]     r_quo,  n_quo;
    logic [mmc_pkg::CHAN_BITS-1:0]     r_mean [mmc_pkg::NUM_CHAN];

    mmc_pkg::t_result r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic                              mean_we;
    logic [mmc_pkg::CHAN_BITS-1:0]     mean_val;
    logic [mmc_pkg::TOTAL_BITS-1:0]    sel_total;
    logic [mmc_pkg::CMP_BITS-1:0]      total_ext;
    logic [mmc_pkg::CMP_BITS-1:0]      count_ext;
    logic                              too_big;
    logic                              ge;
    logic [mmc_pkg::CMP_BITS-1:0]      rem_diff;
    logic                              out_free;

    // channel total under work
    always_comb begin
        case (r_chan)
            2'd0:    sel_total = i_job.red_total;
            2'd1:    sel_total = i_job.green_total;
            2'd2:    sel_total = i_job.blue_total;
            default: sel_total = i_job.blue_total;
        endcase
    end

    assign total_ext = mmc_pkg::CMP_BITS'(sel_total);
    assign count_ext = mmc_pkg::CMP_BITS'(i_job.kept_count);
    // a quotient above the channel range is clamped without dividing
    assign too_big   = total_ext >= (count_ext << mmc_pkg::CHAN_BITS);
    assign ge        = r_rem >= r_dsr;
    assign rem_diff  = r_rem - r_dsr;
    assign out_free  = !r_out_valid || !i_out_stall;

    // sequencer next state and datapath
    always_comb begin
        n_state  = r_state;
        n_chan   = r_chan;
        n_step   = r_step;
        n_rem    = r_rem;
        n_dsr    = r_dsr;
        n_quo    = r_quo;
        mean_we  = 1'b0;
        mean_val = r_quo;
        o_pop    = 1'b0;
        n_out    = r_out;
        case (r_state)
            mmc_pkg::BK_IDLE: begin
                n_chan = '0;
                if (i_q_stat.valid) begin
                    if (i_job.kept_count == '0) begin
                        n_state = mmc_pkg::BK_PUSH;
                    end else begin
                        n_state = mmc_pkg::BK_LOAD;
                    end
                end
            end
            mmc_pkg::BK_LOAD: begin
                if (too_big) begin
                    mean_we  = 1'b1;
                    mean_val = mmc_pkg::MEAN_MAX;
                    if (r_chan == mmc_pkg::LAST_CHAN) begin
                        n_state = mmc_pkg::BK_PUSH;
                    end else begin
                        n_chan = r_chan + 1'b1;
                    end
                end else begin
                    n_rem   = total_ext;
                    n_dsr   = count_ext << (mmc_pkg::CHAN_BITS - 1);
                    n_step  = '0;
                    n_state = mmc_pkg::BK_STEP;
                end
            end
            mmc_pkg::BK_STEP: begin
                // one quotient bit a cycle, most significant first
                n_quo = {r_quo[mmc_pkg::CHAN_BITS-2:0], ge};
                n_rem = ge ? rem_diff : r_rem;
                n_dsr = r_dsr >> 1;
                if (r_step == mmc_pkg::LAST_STEP) begin
                    mean_we  = 1'b1;
                    mean_val = n_quo;
                    if (r_chan == mmc_pkg::LAST_CHAN) begin
                        n_state = mmc_pkg::BK_PUSH;
                    end else begin
                        n_chan  = r_chan + 1'b1;
                        n_state = mmc_pkg::BK_LOAD;
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            mmc_pkg::BK_PUSH: begin
                if (out_free) begin
                    o_pop                 = 1'b1;
                    n_state               = mmc_pkg::BK_IDLE;
                    n_out.count_saturated = i_job.saturated;
                    if (i_job.kept_count == '0) begin
                        n_out.mean_red     = i_defaults.red;
                        n_out.mean_green   = i_defaults.green;
                        n_out.mean_blue    = i_defaults.blue;
                        n_out.used_default = 1'b1;
                    end else begin
                        n_out.mean_red     = r_mean[0];
                        n_out.mean_green   = r_mean[1];
                        n_out.mean_blue    = r_mean[2];
                        n_out.used_default = 1'b0;
                    end
                end
            end
            default: begin
                n_state = mmc_pkg::BK_IDLE;
            end
        endcase
    end

    // output register handshake
    always_comb begin
        if (o_pop) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mmc_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_chan <= n_chan;
        r_step <= n_step;
        r_rem  <= n_rem;
        r_dsr  <= n_dsr;
        r_quo  <= n_quo;
        r_out  <= n_out;
        if (mean_we) begin
            r_mean[r_chan] <= mean_val;
        end
    end

    // the default colour never comes with a saturation report
    a_default_unsat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.used_default |-> !r_out.count_saturated)
        else $error("default colour reported with saturation");

    // restoring division keeps the partial remainder below twice the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mmc_pkg::BK_STEP |-> r_rem < (r_dsr << 1))
        else $error("divider remainder out of range");

    // a job is only retired when one is queued
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_q_stat.valid)
        else $error("job retired from an empty queue");

    // a stalled result is never replaced
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out))
        else $error("pending result overwritten");

endmodule

// ===== tb/sv/tb_masked_mean_color.sv =====
// self-checking testbench for the masked mean colour block
module tb_masked_mean_color;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;

    // clock, reset and block ports
    logic                             i_clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             in_valid = 1'b0;
    mmc_pkg::t_pixel                  in_data = '0;
    logic                             out_stall = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic [mmc_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [mmc_pkg::CHAN_BITS-1:0]    cfg_data = '0;
    logic                             o_in_stall;
    logic                             o_out_valid;
    mmc_pkg::t_result                 o_out_data;
    logic                             o_cfg_ready;

    // pixels waiting to be driven and image results still to come
    mmc_pkg::t_pixel  pixel_q[$];
    mmc_pkg::t_result mean_q[$];

    // local copy of the registers
    logic [mmc_pkg::CHAN_BITS-1:0] alpha_thr  = mmc_pkg::RST_ALPHA_THRESHOLD;
    logic [mmc_pkg::CHAN_BITS-1:0] dflt_red   = mmc_pkg::RST_DEFAULT_RED;
    logic [mmc_pkg::CHAN_BITS-1:0] dflt_green = mmc_pkg::RST_DEFAULT_GREEN;
    logic [mmc_pkg::CHAN_BITS-1:0] dflt_blue  = mmc_pkg::RST_DEFAULT_BLUE;

    // running image sums of the kept pixels
    logic [mmc_pkg::TOTAL_BITS-1:0] red_sum   = '0;
    logic [mmc_pkg::TOTAL_BITS-1:0] green_sum = '0;
    logic [mmc_pkg::TOTAL_BITS-1:0] blue_sum  = '0;
    logic [mmc_pkg::COUNT_BITS-1:0] kept_n    = '0;
    logic                           clipped   = 1'b0;

    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  hold_req    = 1'b0;
    bit  rx_hold     = 1'b0;
    int  err_count   = 0;
    int  cycle_n     = 0;

    masked_mean_color u_top (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // add one channel onto a running total, top bit flags clipping
    function automatic logic [mmc_pkg::TOTAL_BITS:0] add_clip(
            input logic [mmc_pkg::TOTAL_BITS-1:0] total,
            input logic [mmc_pkg::CHAN_BITS-1:0]  val);
        logic [mmc_pkg::TOTAL_BITS-1:0] ceiling;
        ceiling = '1;
        if (total > ceiling - mmc_pkg::TOTAL_BITS'(val))
            return {1'b1, ceiling};
        return {1'b0, total + mmc_pkg::TOTAL_BITS'(val)};
    endfunction

    // truncated mean of one channel, held at full scale
    function automatic logic [mmc_pkg::CHAN_BITS-1:0] chan_mean(
            input logic [mmc_pkg::TOTAL_BITS-1:0] total,
            input logic [mmc_pkg::COUNT_BITS-1:0] n);
        logic [mmc_pkg::TOTAL_BITS-1:0] q;
        q = total / mmc_pkg::TOTAL_BITS'(n);
        return (q > mmc_pkg::TOTAL_BITS'(8'hFF)) ? 8'hFF : q[mmc_pkg::CHAN_BITS-1:0];
    endfunction

    // fold one accepted pixel into the image sums, close the image on its last pixel
    task automatic absorb_pixel(input mmc_pkg::t_pixel px);
        logic [mmc_pkg::TOTAL_BITS:0] r_add, g_add, b_add;
        mmc_pkg::t_result res;
        if (px.alpha >= alpha_thr) begin
            if (kept_n == '1) begin
                clipped = 1'b1;
            end else begin
                r_add = add_clip(red_sum, px.red);
                g_add = add_clip(green_sum, px.green);
                b_add = add_clip(blue_sum, px.blue);
                red_sum   = r_add[mmc_pkg::TOTAL_BITS-1:0];
                green_sum = g_add[mmc_pkg::TOTAL_BITS-1:0];
                blue_sum  = b_add[mmc_pkg::TOTAL_BITS-1:0];
                clipped   = clipped | r_add[mmc_pkg::TOTAL_BITS] | g_add[mmc_pkg::TOTAL_BITS]
                            | b_add[mmc_pkg::TOTAL_BITS];
                kept_n    = kept_n + 1'b1;
            end
        end
        if (px.last_pixel) begin
            if (kept_n == '0) begin
                res.mean_red     = dflt_red;
                res.mean_green   = dflt_green;
                res.mean_blue    = dflt_blue;
                res.used_default = 1'b1;
            end else begin
                res.mean_red     = chan_mean(red_sum, kept_n);
                res.mean_green   = chan_mean(green_sum, kept_n);
                res.mean_blue    = chan_mean(blue_sum, kept_n);
                res.used_default = 1'b0;
            end
            res.count_saturated = clipped;
            mean_q.push_back(res);
            red_sum   = '0;
            green_sum = '0;
            blue_sum  = '0;
            kept_n    = '0;
            clipped   = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    // compare one image result with the oldest expectation
    task automatic check_result(input mmc_pkg::t_result got);
        mmc_pkg::t_result want;
        if (mean_q.size() == 0) begin
            report_mismatch("image result with none expected");
            return;
        end
        want = mean_q.pop_front();
        if (got.mean_red !== want.mean_red)
            report_mismatch($sformatf("mean_red got %0d want %0d", got.mean_red, want.mean_red));
        if (got.mean_green !== want.mean_green)
            report_mismatch($sformatf("mean_green got %0d want %0d",
                                      got.mean_green, want.mean_green));
        if (got.mean_blue !== want.mean_blue)
            report_mismatch($sformatf("mean_blue got %0d want %0d",
                                      got.mean_blue, want.mean_blue));
        if (got.used_default !== want.used_default)
            report_mismatch($sformatf("used_default got %0b want %0b",
                                      got.used_default, want.used_default));
        if (got.count_saturated !== want.count_saturated)
            report_mismatch($sformatf("count_saturated got %0b want %0b",
                                      got.count_saturated, want.count_saturated));
    endtask

    // pixel driver: holds a stalled transaction, idles at random otherwise
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall)
                absorb_pixel(in_data);
            if (!in_valid || !o_in_stall) begin
                if (pixel_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    in_data  <= pixel_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall)
                check_result(o_out_data);
            out_stall <= rx_hold || ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // long receiver hold-off so the block fills and stalls its pixel input
    initial begin
        wait (hold_req);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_n <= cycle_n + 1;
        if (cycle_n == CYCLE_LIMIT) begin
            $display("tb_masked_mean_color: FAIL");
            $finish;
        end
    end

    // register write, only issued while the block is idle
    task automatic write_reg(input mmc_pkg::t_cfg_reg idx,
                             input logic [mmc_pkg::CHAN_BITS-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            mmc_pkg::CFG_ALPHA_THRESHOLD: alpha_thr  = val;
            mmc_pkg::CFG_DEFAULT_RED:     dflt_red   = val;
            mmc_pkg::CFG_DEFAULT_GREEN:   dflt_green = val;
            mmc_pkg::CFG_DEFAULT_BLUE:    dflt_blue  = val;
            default: ;
        endcase
    endtask

    task automatic set_defaults(input logic [mmc_pkg::CHAN_BITS-1:0] r,
                                input logic [mmc_pkg::CHAN_BITS-1:0] g,
                                input logic [mmc_pkg::CHAN_BITS-1:0] b);
        write_reg(mmc_pkg::CFG_DEFAULT_RED, r);
        write_reg(mmc_pkg::CFG_DEFAULT_GREEN, g);
        write_reg(mmc_pkg::CFG_DEFAULT_BLUE, b);
    endtask

    task automatic push_pixel(input logic [mmc_pkg::CHAN_BITS-1:0] r,
                              input logic [mmc_pkg::CHAN_BITS-1:0] g,
                              input logic [mmc_pkg::CHAN_BITS-1:0] b,
                              input logic [mmc_pkg::CHAN_BITS-1:0] a,
                              input logic last);
        mmc_pkg::t_pixel px;
        px.red        = r;
        px.green      = g;
        px.blue       = b;
        px.alpha      = a;
        px.last_pixel = last;
        pixel_q.push_back(px);
    endtask

    // wait until every pixel is accepted and every image result has come back
    task automatic settle();
        while (pixel_q.size() != 0 || in_valid) @(negedge i_clk);
        while (mean_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [mmc_pkg::CHAN_BITS-1:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return mmc_pkg::CHAN_BITS'($urandom);
        endcase
    endfunction

    // alpha biased towards the threshold and the extremes
    function automatic logic [mmc_pkg::CHAN_BITS-1:0] pick_alpha();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return alpha_thr - 1'b1;
            3:       return alpha_thr;
            4:       return alpha_thr + 1'b1;
            default: return mmc_pkg::CHAN_BITS'($urandom);
        endcase
    endfunction

    // one image of random pixels, now and then one where every pixel is masked out
    task automatic queue_image(input int n_pix);
        bit all_dark;
        logic [mmc_pkg::CHAN_BITS-1:0] a;
        all_dark = ($urandom_range(0, 9) == 0) && (alpha_thr != 0);
        for (int k = 0; k < n_pix; k++) begin
            a = all_dark ? mmc_pkg::CHAN_BITS'($urandom_range(0, int'(alpha_thr) - 1))
                         : pick_alpha();
            push_pixel(pick_level(), pick_level(), pick_level(), a, k == n_pix - 1);
        end
    endtask

    task automatic random_phase(input int tx_pct, input int rx_pct, input int n_items,
                                input bit with_hold);
        int queued;
        int pick;
        int n_pix;
        queued = 0;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        while (queued < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                n_pix = $urandom_range(1, 8);
            else if (pick < 95)
                n_pix = $urandom_range(9, 40);
            else
                n_pix = $urandom_range(41, 200);
            queue_image(n_pix);
            queued += n_pix;
        end
        if (with_hold)
            hold_req = 1'b1;
        settle();
    endtask

    // stimulus sequence
    initial begin
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // directed images under the reset register values
        push_pixel(8'd10, 8'd20, 8'd30, 8'd0, 1'b1);
        push_pixel(8'd200, 8'd200, 8'd200, 8'd127, 1'b0);
        push_pixel(8'd255, 8'd0, 8'd255, 8'd128, 1'b0);
        push_pixel(8'd0, 8'd255, 8'd0, 8'd255, 1'b1);
        push_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        push_pixel(8'd0, 8'd0, 8'd0, 8'd128, 1'b1);
        push_pixel(8'd1, 8'd2, 8'd3, 8'd200, 1'b0);
        push_pixel(8'd2, 8'd3, 8'd4, 8'd200, 1'b0);
        push_pixel(8'd4, 8'd4, 8'd4, 8'd200, 1'b1);
        push_pixel(8'd10, 8'd20, 8'd30, 8'd200, 1'b0);
        push_pixel(8'd255, 8'd255, 8'd255, 8'd5, 1'b1);
        push_pixel(8'd170, 8'd85, 8'd15, 8'd127, 1'b0);
        push_pixel(8'd85, 8'd170, 8'd240, 8'd1, 1'b0);
        push_pixel(8'd255, 8'd255, 8'd255, 8'd127, 1'b1);
        push_pixel(8'd254, 8'd1, 8'd128, 8'd129, 1'b0);
        push_pixel(8'd255, 8'd0, 8'd127, 8'd254, 1'b1);
        settle();

        // every pixel kept, black default colour
        write_reg(mmc_pkg::CFG_ALPHA_THRESHOLD, 8'd0);
        set_defaults(8'd0, 8'd0, 8'd0);
        queue_image(3);
        queue_image(1);
        settle();

        // only full alpha kept, with a long output hold-off
        write_reg(mmc_pkg::CFG_ALPHA_THRESHOLD, 8'd255);
        set_defaults(8'd255, 8'd255, 8'd255);
        random_phase(0, 0, 325, 1'b1);

        // mid threshold, sender idling
        write_reg(mmc_pkg::CFG_ALPHA_THRESHOLD, mmc_pkg::CHAN_BITS'($urandom_range(1, 254)));
        set_defaults(mmc_pkg::CHAN_BITS'($urandom), mmc_pkg::CHAN_BITS'($urandom),
                     mmc_pkg::CHAN_BITS'($urandom));
        random_phase(45, 0, 325, 1'b0);

        // threshold of one, receiver stalling
        write_reg(mmc_pkg::CFG_ALPHA_THRESHOLD, 8'd1);
        set_defaults(mmc_pkg::CHAN_BITS'($urandom), mmc_pkg::CHAN_BITS'($urandom),
                     mmc_pkg::CHAN_BITS'($urandom));
        random_phase(0, 45, 325, 1'b0);

        // random threshold, both sides idling
        write_reg(mmc_pkg::CFG_ALPHA_THRESHOLD, mmc_pkg::CHAN_BITS'($urandom));
        set_defaults(mmc_pkg::CHAN_BITS'($urandom), mmc_pkg::CHAN_BITS'($urandom),
                     mmc_pkg::CHAN_BITS'($urandom));
        random_phase(27, 27, 325, 1'b0);

        if (err_count == 0)
            $display("tb_masked_mean_color: PASS");
        else
            $display("tb_masked_mean_color: FAIL");
        $finish;
    end

endmodule
